// ===== src/rcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcr_pkg: shared types, widths and table math for the rectangle rotator
// Holds the field widths, the stage-enable bundle and the functions that
// build the Q1.15 sine/cosine table entries at elaboration.
// ----------------------------------------------------------------------------
package rcr_pkg;

    localparam int COORD_W  = 16;   // signed coordinate fields
    localparam int SIZE_W   = 15;   // unsigned width and height
    localparam int ANGLE_W  = 16;   // fraction of a full turn
    localparam int TRIG_W   = 16;   // Q1.15 sine and cosine
    localparam int OFFSET_W = 16;   // signed corner offset from the center
    localparam int CENTER_W = 17;   // center can exceed the coordinate range
    localparam int PROD_W   = 32;   // offset times Q1.15 value, and their sums
    localparam int ROT_W    = 17;   // rotated offset after dropping 15 bits
    localparam int FULL_W   = 18;   // rotated offset plus center
    localparam int FRAC_BITS = 15;

    localparam logic [63:0] Q29_TWO_PI = 64'd3373259426;
    localparam logic [63:0] Q29_PI     = 64'd1686629713;
    localparam logic [63:0] Q29_ONE    = 64'd536870912;
    localparam int SERIES_TERMS = 26;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sine;
        logic signed [TRIG_W-1:0] cosine;
    } sincos_t;

    // Load enables of the three stages inside each corner lane.
    typedef struct packed {
        logic prod_en;
        logic rot_en;
        logic out_en;
    } stage_en_t;

    // Divides a series term by its index; only used on constants.
    function automatic logic [63:0] term_div(input logic [63:0] x, input int n);
        unique case (n)
            1:       return x / 64'd1;
            2:       return x / 64'd2;
            3:       return x / 64'd3;
            4:       return x / 64'd4;
            5:       return x / 64'd5;
            6:       return x / 64'd6;
            7:       return x / 64'd7;
            8:       return x / 64'd8;
            9:       return x / 64'd9;
            10:      return x / 64'd10;
            11:      return x / 64'd11;
            12:      return x / 64'd12;
            13:      return x / 64'd13;
            14:      return x / 64'd14;
            15:      return x / 64'd15;
            16:      return x / 64'd16;
            17:      return x / 64'd17;
            18:      return x / 64'd18;
            19:      return x / 64'd19;
            20:      return x / 64'd20;
            21:      return x / 64'd21;
            22:      return x / 64'd22;
            23:      return x / 64'd23;
            24:      return x / 64'd24;
            25:      return x / 64'd25;
            26:      return x / 64'd26;
            default: return x;
        endcase
    endfunction

    // Rounds a Q2.29 sum to Q1.15, half up, and saturates.
    function automatic logic signed [TRIG_W-1:0] q15_round_sat(
        input logic signed [63:0] s
    );
        logic signed [63:0] r;
        r = (s + 64'sd8192) >>> 14;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return r[TRIG_W-1:0];
    endfunction

    // Taylor series in Q2.29 for an angle in [0, 2*pi); the upper half
    // is folded back and its sine negated.
    function automatic sincos_t sincos_entry(input logic [63:0] theta);
        logic [63:0]        m;
        logic [63:0]        t;
        logic signed [63:0] ssum;
        logic signed [63:0] csum;
        logic               neg;
        sincos_t            res;
        m    = theta;
        neg  = 1'b0;
        if (theta > Q29_PI) begin
            m   = Q29_TWO_PI - theta;
            neg = 1'b1;
        end
        t    = Q29_ONE;
        ssum = 64'sd0;
        csum = $signed(Q29_ONE);
        for (int n = 1; n <= SERIES_TERMS; n++) begin
            t = term_div((t * m) >> 29, n);
            unique case (2'(n))
                2'd0: csum = csum + $signed(t);
                2'd1: ssum = ssum + $signed(t);
                2'd2: csum = csum - $signed(t);
                2'd3: ssum = ssum - $signed(t);
                default: ssum = ssum;
            endcase
        end
        if (neg) begin
            ssum = -ssum;
        end
        res.sine   = q15_round_sat(ssum);
        res.cosine = q15_round_sat(csum);
        return res;
    endfunction

endpackage

// ===== src/rcr_sincos_rom.sv =====
// ----------------------------------------------------------------------------
// rcr_sincos_rom: sine/cosine lookup table
// Constant table of Q1.15 sine and cosine, built at elaboration, with a
// registered read port and a load enable.
// ----------------------------------------------------------------------------
module rcr_sincos_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
    output rcr_pkg::sincos_t                    data
);
    import rcr_pkg::*;

    sincos_t rom_mem [SINE_TABLE_DEPTH];
    sincos_t data_reg;

    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_entry
        localparam logic [63:0] Theta = (64'(i) * Q29_TWO_PI) / 64'(SINE_TABLE_DEPTH);
        localparam sincos_t Entry = sincos_entry(Theta);
        assign rom_mem[i] = Entry;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom_mem[addr];
        end
    end

    assign data = data_reg;

endmodule

// ===== src/rcr_corner_lane.sv =====
// ----------------------------------------------------------------------------
// rcr_corner_lane: rotation of one corner about the center
// Three stages: products, truncated sums, and center add-back with wrap to
// the configured coordinate width.
// ----------------------------------------------------------------------------
module rcr_corner_lane #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  rcr_pkg::stage_en_t                    en,
    input  logic signed [rcr_pkg::OFFSET_W-1:0]   dx,
    input  logic signed [rcr_pkg::OFFSET_W-1:0]   dy,
    input  rcr_pkg::sincos_t                      trig,
    input  logic signed [rcr_pkg::CENTER_W-1:0]   cx,
    input  logic signed [rcr_pkg::CENTER_W-1:0]   cy,
    output logic signed [rcr_pkg::COORD_W-1:0]    corner_x,
    output logic signed [rcr_pkg::COORD_W-1:0]    corner_y
);
    import rcr_pkg::*;

    // Only the low WRAP_BITS bits survive; the rest of the field repeats the sign.
    localparam int WRAP_BITS = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

    logic signed [PROD_W-1:0]   xc_reg;
    logic signed [PROD_W-1:0]   xs_reg;
    logic signed [PROD_W-1:0]   yc_reg;
    logic signed [PROD_W-1:0]   ys_reg;
    logic signed [CENTER_W-1:0] cx_p_reg;
    logic signed [CENTER_W-1:0] cy_p_reg;

    logic signed [PROD_W-1:0]   sum_x;
    logic signed [PROD_W-1:0]   sum_y;
    logic signed [PROD_W-1:0]   adj_x;
    logic signed [PROD_W-1:0]   adj_y;
    logic signed [ROT_W-1:0]    rot_x_next;
    logic signed [ROT_W-1:0]    rot_y_next;
    logic signed [ROT_W-1:0]    rot_x_reg;
    logic signed [ROT_W-1:0]    rot_y_reg;
    logic signed [CENTER_W-1:0] cx_r_reg;
    logic signed [CENTER_W-1:0] cy_r_reg;

    logic signed [FULL_W-1:0]   full_x;
    logic signed [FULL_W-1:0]   full_y;
    logic signed [COORD_W-1:0]  corner_x_next;
    logic signed [COORD_W-1:0]  corner_y_next;
    logic signed [COORD_W-1:0]  corner_x_reg;
    logic signed [COORD_W-1:0]  corner_y_reg;

    always_ff @(posedge clk)
    begin
        if (en.prod_en)
        begin
            xc_reg   <= PROD_W'(dx) * PROD_W'(trig.cosine);
            xs_reg   <= PROD_W'(dx) * PROD_W'(trig.sine);
            yc_reg   <= PROD_W'(dy) * PROD_W'(trig.cosine);
            ys_reg   <= PROD_W'(dy) * PROD_W'(trig.sine);
            cx_p_reg <= cx;
            cy_p_reg <= cy;
        end
    end

    // Division by 2^15 rounding toward zero: bias negative sums before the shift.
    always_comb
    begin
        sum_x = xc_reg - ys_reg;
        sum_y = yc_reg + xs_reg;
        adj_x = sum_x + (sum_x[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
        adj_y = sum_y + (sum_y[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
        rot_x_next = adj_x[FRAC_BITS +: ROT_W];
        rot_y_next = adj_y[FRAC_BITS +: ROT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.rot_en)
        begin
            rot_x_reg <= rot_x_next;
            rot_y_reg <= rot_y_next;
            cx_r_reg  <= cx_p_reg;
            cy_r_reg  <= cy_p_reg;
        end
    end

    always_comb
    begin
        full_x = FULL_W'(rot_x_reg) + FULL_W'(cx_r_reg);
        full_y = FULL_W'(rot_y_reg) + FULL_W'(cy_r_reg);
        for (int b = 0; b < COORD_W; b++)
        begin
            corner_x_next[b] = (b < WRAP_BITS) ? full_x[b] : full_x[WRAP_BITS-1];
            corner_y_next[b] = (b < WRAP_BITS) ? full_y[b] : full_y[WRAP_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.out_en)
        begin
            corner_x_reg <= corner_x_next;
            corner_y_reg <= corner_y_next;
        end
    end

    assign corner_x = corner_x_reg;
    assign corner_y = corner_y_reg;

endmodule

// ===== src/rect_corner_rotator.sv =====
// Path: an accepted beat passes the stage 1, product, rotation and output registers.
// Throughput: one rectangle per cycle while out_stall is low; the four stages
// advance independently, so a stalled output still lets earlier stages close up bubbles.
// Input stall rises only when every stage holds a beat and the output is stalled.
// Reset clears the stage valid bits only; the sine table is constant and
// needs no fill after reset.
// ----------------------------------------------------------------------------
// rect_corner_rotator: rotates the four corners of a rectangle about its center
// Stage 1 registers offsets, center and the table lookup; four corner lanes
// then multiply, truncate and add the center back.
// ----------------------------------------------------------------------------
module rect_corner_rotator #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int COORD_BITS       = 16
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] rect_left,
    input  logic signed [15:0] rect_top,
    input  logic [14:0]        rect_width,
    input  logic [14:0]        rect_height,
    input  logic [15:0]        turn_angle,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] corner0_x,
    output logic signed [15:0] corner0_y,
    output logic signed [15:0] corner1_x,
    output logic signed [15:0] corner1_y,
    output logic signed [15:0] corner2_x,
    output logic signed [15:0] corner2_y,
    output logic signed [15:0] corner3_x,
    output logic signed [15:0] corner3_y
);
    import rcr_pkg::*;

    localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int SCALE_W   = ANGLE_W + ADDR_BITS + 1;

    logic [SCALE_W-1:0]        angle_scaled;
    logic [ADDR_BITS-1:0]      table_addr;
    logic [SIZE_W-2:0]         half_w;
    logic [SIZE_W-2:0]         half_h;

    logic signed [OFFSET_W-1:0] dx_l_reg;
    logic signed [OFFSET_W-1:0] dx_r_reg;
    logic signed [OFFSET_W-1:0] dy_t_reg;
    logic signed [OFFSET_W-1:0] dy_b_reg;
    logic signed [CENTER_W-1:0] cx_reg;
    logic signed [CENTER_W-1:0] cy_reg;
    sincos_t                    trig;

    logic      s1_valid_reg;
    logic      s2_valid_reg;
    logic      s3_valid_reg;
    logic      s4_valid_reg;
    logic      s1_en;
    stage_en_t lane_en;

    // Each stage loads when it is empty or its successor loads this cycle.
    always_comb
    begin
        lane_en.out_en  = !s4_valid_reg || !out_stall;
        lane_en.rot_en  = !s3_valid_reg || lane_en.out_en;
        lane_en.prod_en = !s2_valid_reg || lane_en.rot_en;
        s1_en           = !s1_valid_reg || lane_en.prod_en;
    end

    assign in_stall  = !s1_en;
    assign out_valid = s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= in_valid;
            end
            if (lane_en.prod_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (lane_en.rot_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (lane_en.out_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_comb
    begin
        angle_scaled = SCALE_W'(turn_angle) * SCALE_W'(SINE_TABLE_DEPTH);
        table_addr   = angle_scaled[ANGLE_W +: ADDR_BITS];
        half_w       = rect_width[SIZE_W-1:1];
        half_h       = rect_height[SIZE_W-1:1];
    end

    // Right and bottom offsets are the halves rounded up: half plus the odd bit.
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            dx_l_reg <= -$signed(OFFSET_W'(half_w));
            dx_r_reg <= $signed(OFFSET_W'(half_w) + OFFSET_W'(rect_width[0]));
            dy_t_reg <= -$signed(OFFSET_W'(half_h));
            dy_b_reg <= $signed(OFFSET_W'(half_h) + OFFSET_W'(rect_height[0]));
            cx_reg   <= $signed(CENTER_W'(rect_left) + CENTER_W'(half_w));
            cy_reg   <= $signed(CENTER_W'(rect_top) + CENTER_W'(half_h));
        end
    end

    rcr_sincos_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .en   (s1_en),
        .addr (table_addr),
        .data (trig)
    );

    rcr_corner_lane #(.COORD_BITS(COORD_BITS)) u_corner0 (
        .clk      (clk),
        .en       (lane_en),
        .dx       (dx_l_reg),
        .dy       (dy_t_reg),
        .trig     (trig),
        .cx       (cx_reg),
        .cy       (cy_reg),
        .corner_x (corner0_x),
        .corner_y (corner0_y)
    );

    rcr_corner_lane #(.COORD_BITS(COORD_BITS)) u_corner1 (
        .clk      (clk),
        .en       (lane_en),
        .dx       (dx_r_reg),
        .dy       (dy_t_reg),
        .trig     (trig),
        .cx       (cx_reg),
        .cy       (cy_reg),
        .corner_x (corner1_x),
        .corner_y (corner1_y)
    );

    rcr_corner_lane #(.COORD_BITS(COORD_BITS)) u_corner2 (
        .clk      (clk),
        .en       (lane_en),
        .dx       (dx_r_reg),
        .dy       (dy_b_reg),
        .trig     (trig),
        .cx       (cx_reg),
        .cy       (cy_reg),
        .corner_x (corner2_x),
        .corner_y (corner2_y)
    );

    rcr_corner_lane #(.COORD_BITS(COORD_BITS)) u_corner3 (
        .clk      (clk),
        .en       (lane_en),
        .dx       (dx_l_reg),
        .dy       (dy_b_reg),
        .trig     (trig),
        .cx       (cx_reg),
        .cy       (cy_reg),
        .corner_x (corner3_x),
        .corner_y (corner3_y)
    );

`ifndef ASSERT_OFF
    // The input may only stall when the whole pipeline is full and blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                      && s4_valid_reg && out_stall))
        else $error("input stalled while the pipeline had room");

    // An accepted beat occupies stage 1 on the next cycle.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat lost before stage 1");

    // A beat in stage 3 moves to the output unless the output is blocked.
    a_s3_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !(out_valid && out_stall)) |=> out_valid)
        else $error("stage 3 beat did not reach the output");
`endif

endmodule
